// ===== hdl/ndq_pkg.sv =====
package ndq_pkg;

  localparam int unsigned BaseCount = 162;
  localparam int unsigned KindBits = 1;
  localparam int unsigned CodeBits = 8;

  typedef enum logic [KindBits-1:0] {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  // Magnitude constants in Q1.23, indexed by the selector used in the base table.
  typedef enum logic [4:0] {
    KZ, K525, K851, K443, K239, K864, K295, K955, K309, K500, K809, K162,
    K263, K951, K1, K148, K717, K682, K588, K425, K688
  } kmag_e;

  function automatic logic [23:0] kmag_value(input kmag_e k);
    logic [23:0] v;
    case (k)
      K525: v = 24'd4410151;
      K851: v = 24'd7135778;
      K443: v = 24'd3715004;
      K239: v = 24'd2003669;
      K864: v = 24'd7249334;
      K295: v = 24'd2476669;
      K955: v = 24'd8014669;
      K309: v = 24'd2592222;
      K500: v = 24'd4194304;
      K809: v = 24'd6786526;
      K162: v = 24'd1362813;
      K263: v = 24'd2205080;
      K951: v = 24'd7978036;
      K1:   v = 24'd8388608;
      K148: v = 24'd1238335;
      K717: v = 24'd6011000;
      K682: v = 24'd5718665;
      K588: v = 24'd4930698;
      K425: v = 24'd3567885;
      K688: v = 24'd5772965;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // One component of the base set: a sign and a magnitude selector.
  typedef struct packed {
    logic  neg;
    kmag_e mag;
  } bcomp_t;

  typedef struct packed {
    bcomp_t x;
    bcomp_t y;
    bcomp_t z;
  } bvec_t;

  function automatic bcomp_t p(input kmag_e k);
    return '{neg: 1'b0, mag: k};
  endfunction

  function automatic bcomp_t n(input kmag_e k);
    return '{neg: 1'b1, mag: k};
  endfunction

  function automatic bvec_t v3(input bcomp_t a, input bcomp_t b, input bcomp_t c);
    return '{x: a, y: b, z: c};
  endfunction

  function automatic bvec_t base_vec(input logic [CodeBits-1:0] i);
    bvec_t r;
    case (i)
      8'd0: r = v3(n(K525), p(KZ), p(K851));
      8'd1: r = v3(n(K443), p(K239), p(K864));
      8'd2: r = v3(n(K295), p(KZ), p(K955));
      8'd3: r = v3(n(K309), p(K500), p(K809));
      8'd4: r = v3(n(K162), p(K263), p(K951));
      8'd5: r = v3(p(KZ), p(KZ), p(K1));
      8'd6: r = v3(p(KZ), p(K851), p(K525));
      8'd7: r = v3(n(K148), p(K717), p(K682));
      8'd8: r = v3(p(K148), p(K717), p(K682));
      8'd9: r = v3(p(KZ), p(K525), p(K851));
      8'd10: r = v3(p(K309), p(K500), p(K809));
      8'd11: r = v3(p(K525), p(KZ), p(K851));
      8'd12: r = v3(p(K295), p(KZ), p(K955));
      8'd13: r = v3(p(K443), p(K239), p(K864));
      8'd14: r = v3(p(K162), p(K263), p(K951));
      8'd15: r = v3(n(K682), p(K148), p(K717));
      8'd16: r = v3(n(K809), p(K309), p(K500));
      8'd17: r = v3(n(K588), p(K425), p(K688));
      8'd18: r = v3(n(K851), p(K525), p(KZ));
      8'd19: r = v3(n(K864), p(K443), p(K239));
      8'd20: r = v3(n(K717), p(K682), p(K148));
      8'd21: r = v3(n(K688), p(K588), p(K425));
      8'd22: r = v3(n(K500), p(K809), p(K309));
      8'd23: r = v3(n(K239), p(K864), p(K443));
      8'd24: r = v3(n(K425), p(K688), p(K588));
      8'd25: r = v3(n(K717), p(K682), n(K148));
      8'd26: r = v3(n(K500), p(K809), n(K309));
      8'd27: r = v3(n(K525), p(K851), p(KZ));
      8'd28: r = v3(p(KZ), p(K851), n(K525));
      8'd29: r = v3(n(K239), p(K864), n(K443));
      8'd30: r = v3(p(KZ), p(K955), n(K295));
      8'd31: r = v3(n(K263), p(K951), n(K162));
      8'd32: r = v3(p(KZ), p(K1), p(KZ));
      8'd33: r = v3(p(KZ), p(K955), p(K295));
      8'd34: r = v3(n(K263), p(K951), p(K162));
      8'd35: r = v3(p(K239), p(K864), p(K443));
      8'd36: r = v3(p(K263), p(K951), p(K162));
      8'd37: r = v3(p(K500), p(K809), p(K309));
      8'd38: r = v3(p(K239), p(K864), n(K443));
      8'd39: r = v3(p(K263), p(K951), n(K162));
      8'd40: r = v3(p(K500), p(K809), n(K309));
      8'd41: r = v3(p(K851), p(K525), p(KZ));
      8'd42: r = v3(p(K717), p(K682), p(K148));
      8'd43: r = v3(p(K717), p(K682), n(K148));
      8'd44: r = v3(p(K525), p(K851), p(KZ));
      8'd45: r = v3(p(K425), p(K688), p(K588));
      8'd46: r = v3(p(K864), p(K443), p(K239));
      8'd47: r = v3(p(K688), p(K588), p(K425));
      8'd48: r = v3(p(K809), p(K309), p(K500));
      8'd49: r = v3(p(K682), p(K148), p(K717));
      8'd50: r = v3(p(K588), p(K425), p(K688));
      8'd51: r = v3(p(K955), p(K295), p(KZ));
      8'd52: r = v3(p(K1), p(KZ), p(KZ));
      8'd53: r = v3(p(K951), p(K162), p(K263));
      8'd54: r = v3(p(K851), n(K525), p(KZ));
      8'd55: r = v3(p(K955), n(K295), p(KZ));
      8'd56: r = v3(p(K864), n(K443), p(K239));
      8'd57: r = v3(p(K951), n(K162), p(K263));
      8'd58: r = v3(p(K809), n(K309), p(K500));
      8'd59: r = v3(p(K682), n(K148), p(K717));
      8'd60: r = v3(p(K851), p(KZ), p(K525));
      8'd61: r = v3(p(K864), p(K443), n(K239));
      8'd62: r = v3(p(K809), p(K309), n(K500));
      8'd63: r = v3(p(K951), p(K162), n(K263));
      8'd64: r = v3(p(K525), p(KZ), n(K851));
      8'd65: r = v3(p(K682), p(K148), n(K717));
      8'd66: r = v3(p(K682), n(K148), n(K717));
      8'd67: r = v3(p(K851), p(KZ), n(K525));
      8'd68: r = v3(p(K809), n(K309), n(K500));
      8'd69: r = v3(p(K864), n(K443), n(K239));
      8'd70: r = v3(p(K951), n(K162), n(K263));
      8'd71: r = v3(p(K148), p(K717), n(K682));
      8'd72: r = v3(p(K309), p(K500), n(K809));
      8'd73: r = v3(p(K425), p(K688), n(K588));
      8'd74: r = v3(p(K443), p(K239), n(K864));
      8'd75: r = v3(p(K588), p(K425), n(K688));
      8'd76: r = v3(p(K688), p(K588), n(K425));
      8'd77: r = v3(n(K148), p(K717), n(K682));
      8'd78: r = v3(n(K309), p(K500), n(K809));
      8'd79: r = v3(p(KZ), p(K525), n(K851));
      8'd80: r = v3(n(K525), p(KZ), n(K851));
      8'd81: r = v3(n(K443), p(K239), n(K864));
      8'd82: r = v3(n(K295), p(KZ), n(K955));
      8'd83: r = v3(n(K162), p(K263), n(K951));
      8'd84: r = v3(p(KZ), p(KZ), n(K1));
      8'd85: r = v3(p(K295), p(KZ), n(K955));
      8'd86: r = v3(p(K162), p(K263), n(K951));
      8'd87: r = v3(n(K443), n(K239), n(K864));
      8'd88: r = v3(n(K309), n(K500), n(K809));
      8'd89: r = v3(n(K162), n(K263), n(K951));
      8'd90: r = v3(p(KZ), n(K851), n(K525));
      8'd91: r = v3(n(K148), n(K717), n(K682));
      8'd92: r = v3(p(K148), n(K717), n(K682));
      8'd93: r = v3(p(KZ), n(K525), n(K851));
      8'd94: r = v3(p(K309), n(K500), n(K809));
      8'd95: r = v3(p(K443), n(K239), n(K864));
      8'd96: r = v3(p(K162), n(K263), n(K951));
      8'd97: r = v3(p(K239), n(K864), n(K443));
      8'd98: r = v3(p(K500), n(K809), n(K309));
      8'd99: r = v3(p(K425), n(K688), n(K588));
      8'd100: r = v3(p(K717), n(K682), n(K148));
      8'd101: r = v3(p(K688), n(K588), n(K425));
      8'd102: r = v3(p(K588), n(K425), n(K688));
      8'd103: r = v3(p(KZ), n(K955), n(K295));
      8'd104: r = v3(p(KZ), n(K1), p(KZ));
      8'd105: r = v3(p(K263), n(K951), n(K162));
      8'd106: r = v3(p(KZ), n(K851), p(K525));
      8'd107: r = v3(p(KZ), n(K955), p(K295));
      8'd108: r = v3(p(K239), n(K864), p(K443));
      8'd109: r = v3(p(K263), n(K951), p(K162));
      8'd110: r = v3(p(K500), n(K809), p(K309));
      8'd111: r = v3(p(K717), n(K682), p(K148));
      8'd112: r = v3(p(K525), n(K851), p(KZ));
      8'd113: r = v3(n(K239), n(K864), n(K443));
      8'd114: r = v3(n(K500), n(K809), n(K309));
      8'd115: r = v3(n(K263), n(K951), n(K162));
      8'd116: r = v3(n(K851), n(K525), p(KZ));
      8'd117: r = v3(n(K717), n(K682), n(K148));
      8'd118: r = v3(n(K717), n(K682), p(K148));
      8'd119: r = v3(n(K525), n(K851), p(KZ));
      8'd120: r = v3(n(K500), n(K809), p(K309));
      8'd121: r = v3(n(K239), n(K864), p(K443));
      8'd122: r = v3(n(K263), n(K951), p(K162));
      8'd123: r = v3(n(K864), n(K443), p(K239));
      8'd124: r = v3(n(K809), n(K309), p(K500));
      8'd125: r = v3(n(K688), n(K588), p(K425));
      8'd126: r = v3(n(K682), n(K148), p(K717));
      8'd127: r = v3(n(K443), n(K239), p(K864));
      8'd128: r = v3(n(K588), n(K425), p(K688));
      8'd129: r = v3(n(K309), n(K500), p(K809));
      8'd130: r = v3(n(K148), n(K717), p(K682));
      8'd131: r = v3(n(K425), n(K688), p(K588));
      8'd132: r = v3(n(K162), n(K263), p(K951));
      8'd133: r = v3(p(K443), n(K239), p(K864));
      8'd134: r = v3(p(K162), n(K263), p(K951));
      8'd135: r = v3(p(K309), n(K500), p(K809));
      8'd136: r = v3(p(K148), n(K717), p(K682));
      8'd137: r = v3(p(KZ), n(K525), p(K851));
      8'd138: r = v3(p(K425), n(K688), p(K588));
      8'd139: r = v3(p(K588), n(K425), p(K688));
      8'd140: r = v3(p(K688), n(K588), p(K425));
      8'd141: r = v3(n(K955), p(K295), p(KZ));
      8'd142: r = v3(n(K951), p(K162), p(K263));
      8'd143: r = v3(n(K1), p(KZ), p(KZ));
      8'd144: r = v3(n(K851), p(KZ), p(K525));
      8'd145: r = v3(n(K955), n(K295), p(KZ));
      8'd146: r = v3(n(K951), n(K162), p(K263));
      8'd147: r = v3(n(K864), p(K443), n(K239));
      8'd148: r = v3(n(K951), p(K162), n(K263));
      8'd149: r = v3(n(K809), p(K309), n(K500));
      8'd150: r = v3(n(K864), n(K443), n(K239));
      8'd151: r = v3(n(K951), n(K162), n(K263));
      8'd152: r = v3(n(K809), n(K309), n(K500));
      8'd153: r = v3(n(K682), p(K148), n(K717));
      8'd154: r = v3(n(K682), n(K148), n(K717));
      8'd155: r = v3(n(K851), p(KZ), n(K525));
      8'd156: r = v3(n(K688), p(K588), n(K425));
      8'd157: r = v3(n(K588), p(K425), n(K688));
      8'd158: r = v3(n(K425), p(K688), n(K588));
      8'd159: r = v3(n(K425), n(K688), n(K588));
      8'd160: r = v3(n(K588), n(K425), n(K688));
      8'd161: r = v3(n(K688), n(K588), n(K425));
      default: r = v3(p(KZ), p(KZ), p(KZ));
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/normal_direction_quantizer.sv =====
// Normal direction quantizer. Each input beat carries a kind flag (tuser): an
// encode beat maps a signed Q1.(COMPONENT_BITS-1) direction to the index of
// the table normal with the largest exact dot product (first maximum wins,
// code 0 when no dot product is positive); a decode beat maps a code back to
// its table normal, or to the zero vector for a code of NUM_NORMALS or more.
// The normals live in one synchronous read-only memory, loaded by a fill
// pass over all NUM_NORMALS entries after reset during which no beat is
// accepted. One multiplier is shared across the three components, so an
// encode walks every table entry one component at a time, while a decode
// passes through ST_DREAD, ST_DWAIT and ST_OUT. One beat is worked on at a
// time, and a new beat is taken once the previous result has left the
// output register.
module normal_direction_quantizer #(
  parameter int unsigned NUM_NORMALS    = 162,
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, from bit 0: dir_x, dir_y, dir_z, code_in, zero fill.
  input  logic [((3*COMPONENT_BITS+8+7)/8)*8-1:0] s_axis_tdata,
  // tuser: kind.
  input  logic [ndq_pkg::KindBits-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, from bit 0: code_out, vec_x, vec_y, vec_z, zero fill.
  output logic [((3*COMPONENT_BITS+8+7)/8)*8-1:0] m_axis_tdata
);
  import ndq_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned DW    = ((3*CB+8+7)/8)*8;
  localparam int unsigned AW    = (NUM_NORMALS > 1) ? $clog2(NUM_NORMALS) : 1;
  localparam int unsigned PW    = 2*CB;
  localparam int unsigned SW    = 2*CB + 2;
  localparam int unsigned SHIFT = 24 - CB;
  localparam logic [23:0] MAXV  = 24'((1 << (CB-1)) - 1);
  localparam logic [AW:0] LAST  = (AW+1)'(NUM_NORMALS - 1);

  typedef enum logic [2:0] {
    ST_FILL, ST_IDLE, ST_DREAD, ST_DWAIT, ST_ERUN, ST_EDRAIN, ST_OUT
  } state_e;

  state_e            state_q;
  logic [AW:0]       fill_q;
  logic [AW:0]       idx_q;
  logic [1:0]        comp_q;
  logic              kind_q;
  logic [7:0]        code_q;
  logic signed [CB-1:0] dir_q [3];
  logic signed [CB-1:0] vec_q [3];
  logic [DW-1:0]     out_q;
  logic              ovalid_q;

  // Normal memory: one entry per normal, three components packed.
  logic [3*CB-1:0]   mem [NUM_NORMALS];
  logic [3*CB-1:0]   rd_q;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  // Reduction of a base component to the stored width.
  function automatic logic signed [CB-1:0] reduce(input bcomp_t c);
    logic [24:0] mag;
    logic [24:0] r;
    logic [CB-1:0] m;
    mag = {1'b0, kmag_value(c.mag)};
    if (SHIFT > 0) r = (mag + (25'd1 << (SHIFT-1))) >> SHIFT;
    else r = mag;
    if (r > {1'b0, MAXV}) r = {1'b0, MAXV};
    m = r[CB-1:0];
    return c.neg ? -$signed(m) : $signed(m);
  endfunction

  bvec_t bv;
  logic [3*CB-1:0] fill_word;
  always_comb begin
    bv = base_vec(32'(fill_q) >= BaseCount ? 8'hFF : 8'(fill_q[AW-1:0]));
    fill_word = {reduce(bv.z), reduce(bv.y), reduce(bv.x)};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) mem[fill_q[AW-1:0]] <= fill_word;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Shared multiply-accumulate path.
  logic signed [CB-1:0] tcomp;
  logic signed [CB-1:0] dcomp;
  logic signed [PW-1:0] prod_q;
  logic                 pvalid_q;
  logic                 plast_q;
  logic [AW-1:0]        pidx_q;
  logic signed [SW-1:0] acc_q;
  logic signed [SW-1:0] best_q;
  logic [AW-1:0]        besti_q;
  logic [1:0]           rcomp_q;
  logic [AW-1:0]        ridx_q;
  logic signed [SW-1:0] acc_d;

  always_comb begin
    case (rcomp_q)
      2'd0: begin tcomp = $signed(rd_q[CB-1:0]); dcomp = dir_q[0]; end
      2'd1: begin tcomp = $signed(rd_q[2*CB-1:CB]); dcomp = dir_q[1]; end
      default: begin tcomp = $signed(rd_q[3*CB-1:2*CB]); dcomp = dir_q[2]; end
    endcase
    acc_d = acc_q + SW'(prod_q);
  end

  logic enc_busy;
  assign enc_busy = (state_q == ST_ERUN);
  assign rd_addr  = (state_q == ST_DREAD) ? code_q[AW-1:0] : idx_q[AW-1:0];
  assign rd_en    = (state_q == ST_DREAD) || (enc_busy && comp_q == 2'd0);

  logic [7:0]  in_code;
  logic        accept;
  assign in_code       = s_axis_tdata[3*CB +: 8];
  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  logic [DW-1:0] res;
  always_comb begin
    res = '0;
    if (kind_q == KIND_ENCODE) res[7:0] = 8'(besti_q);
    else begin
      res[8 +: CB]      = vec_q[0];
      res[8+CB +: CB]   = vec_q[1];
      res[8+2*CB +: CB] = vec_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      fill_q   <= '0;
      idx_q    <= '0;
      comp_q   <= '0;
      ovalid_q <= 1'b0;
      pvalid_q <= 1'b0;
      rcomp_q  <= 2'd3;
      kind_q   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      pvalid_q <= 1'b0;
      case (state_q)
        ST_FILL: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == LAST) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            kind_q <= s_axis_tuser;
            code_q <= in_code;
            dir_q[0] <= $signed(s_axis_tdata[CB-1:0]);
            dir_q[1] <= $signed(s_axis_tdata[2*CB-1:CB]);
            dir_q[2] <= $signed(s_axis_tdata[3*CB-1:2*CB]);
            idx_q  <= '0;
            comp_q <= '0;
            acc_q  <= '0;
            best_q <= '0;
            besti_q <= '0;
            state_q <= (s_axis_tuser == KIND_DECODE) ? ST_DREAD : ST_ERUN;
          end
        end
        ST_DREAD: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if ({1'b0, code_q} < 9'(NUM_NORMALS)) begin
            vec_q[0] <= $signed(rd_q[CB-1:0]);
            vec_q[1] <= $signed(rd_q[2*CB-1:CB]);
            vec_q[2] <= $signed(rd_q[3*CB-1:2*CB]);
          end else begin
            vec_q[0] <= '0; vec_q[1] <= '0; vec_q[2] <= '0;
          end
          state_q <= ST_OUT;
        end
        ST_ERUN: begin
          // The read is issued at comp 0; rd_q holds the entry until the next read.
          if (comp_q == 2'd0) ridx_q <= idx_q[AW-1:0];
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            idx_q  <= idx_q + 1'b1;
            if (idx_q == LAST) state_q <= ST_EDRAIN;
          end else comp_q <= comp_q + 1'b1;
          fill_q <= '0;
        end
        ST_EDRAIN: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == (AW+1)'(1)) state_q <= ST_OUT;
        end
        ST_OUT: begin
          ovalid_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      // rcomp walks the three components of the entry held in rd_q
      if (enc_busy && comp_q == 2'd0) rcomp_q <= 2'd0;
      else if (rcomp_q != 2'd3) rcomp_q <= rcomp_q + 1'b1;
      if (rcomp_q != 2'd3 && (enc_busy || state_q == ST_EDRAIN)) begin
        prod_q   <= tcomp * dcomp;
        pvalid_q <= 1'b1;
        plast_q  <= (rcomp_q == 2'd2);
        pidx_q   <= ridx_q;
      end
      if (pvalid_q) begin
        if (plast_q) begin
          acc_q <= '0;
          if (acc_d > best_q) begin
            best_q  <= acc_d;
            besti_q <= pidx_q;
          end
        end else acc_q <= acc_d;
      end
      if (state_q == ST_OUT) out_q <= res;
    end
  end

endmodule

// ===== hdl/ndq_checker.sv =====
module ndq_assertions #(
  parameter int unsigned DW = 56
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [DW-1:0] m_axis_tdata
);

  // A result that waits holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No input is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while output pending");

  // A result never appears in the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind normal_direction_quantizer ndq_assertions #(.DW($bits(m_axis_tdata))) u_ndq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ===== tb/ndq_checker.sv =====
module ndq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  output int          mismatches_o,
  output int          outstanding_o
);
  import ndq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         code;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } quant_result_t;

  quant_result_t result_fifo[$];
  logic signed [15:0] normals[162][3];

  // Q1.23 magnitudes, indexed by the package selector.
  function automatic int unsigned mag_q23(input kmag_e k);
    case (k)
      K525: return 4410151;  K851: return 7135778;  K443: return 3715004;
      K239: return 2003669;  K864: return 7249334;  K295: return 2476669;
      K955: return 8014669;  K309: return 2592222;  K500: return 4194304;
      K809: return 6786526;  K162: return 1362813;  K263: return 2205080;
      K951: return 7978036;  K1:   return 8388608;  K148: return 1238335;
      K717: return 6011000;  K682: return 5718665;  K588: return 4930698;
      K425: return 3567885;  K688: return 5772965;
      default: return 0;
    endcase
  endfunction

  // Round the magnitude half up to Q1.15, saturate, then apply the sign.
  function automatic logic signed [15:0] to_q15(input bcomp_t c);
    int unsigned m;
    m = (mag_q23(c.mag) + 128) >> 8;
    if (m > 32767) m = 32767;
    return c.neg ? -$signed(16'(m)) : $signed(16'(m));
  endfunction

  initial begin
    bvec_t b;
    for (int i = 0; i < 162; i++) begin
      b = base_vec(8'(i));
      normals[i][0] = to_q15(b.x);
      normals[i][1] = to_q15(b.y);
      normals[i][2] = to_q15(b.z);
    end
  end

  function automatic quant_result_t quantize(input logic kind, input logic [55:0] d);
    quant_result_t r;
    longint best_dot, dot;
    logic [7:0] c;
    r = '0;
    if (kind_e'(kind) == KIND_ENCODE) begin
      best_dot = 0;
      for (int i = 0; i < 162; i++) begin
        dot = longint'($signed(d[15:0])) * normals[i][0]
            + longint'($signed(d[31:16])) * normals[i][1]
            + longint'($signed(d[47:32])) * normals[i][2];
        // Strict compare keeps the lowest index on ties.
        if (dot > best_dot) begin
          best_dot = dot;
          r.code = 8'(i);
        end
      end
    end else begin
      c = d[55:48];
      if (c < 162) begin
        r.vx = normals[c][0];
        r.vy = normals[c][1];
        r.vz = normals[c][2];
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("ndq_checker: %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    quant_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        result_fifo.push_back(quantize(s_axis_tuser[0], s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_fifo.size() == 0) begin
          report("unexpected result beat, code", m_axis_tdata[7:0], -1);
        end else begin
          want = result_fifo.pop_front();
          if (m_axis_tdata[7:0] !== want.code)
            report("code_out", m_axis_tdata[7:0], want.code);
          if (m_axis_tdata[23:8] !== want.vx)
            report("vec_x", $signed(m_axis_tdata[23:8]), want.vx);
          if (m_axis_tdata[39:24] !== want.vy)
            report("vec_y", $signed(m_axis_tdata[39:24]), want.vy);
          if (m_axis_tdata[55:40] !== want.vz)
            report("vec_z", $signed(m_axis_tdata[55:40]), want.vz);
          if ($isunknown(m_axis_tdata))
            report("unknown bits in result", 0, 0);
        end
      end
      outstanding_o = result_fifo.size();
    end
  end

endmodule

// ===== tb/normal_direction_quantizer_tb.sv =====
module normal_direction_quantizer_tb;
  import ndq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata, from bit 0: dir_x, dir_y, dir_z, code_in.
  logic [55:0] s_axis_tdata;
  // tuser: kind.
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata, from bit 0: code_out, vec_x, vec_y, vec_z.
  logic [55:0] m_axis_tdata;

  int mismatches, outstanding;
  int n_encode, n_decode;
  int burst_left;
  // Set by the stimulus to request one long receiver hold-off.
  int hold_request;

  normal_direction_quantizer i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  ndq_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The 50 ms limit leaves a wide margin even for the slow encodes.
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // Receiver: its readiness mode is redrawn periodically from always ready, mostly
  // ready and mostly stalled. A hold request overrides it for a long stretch.
  initial begin
    int pct, tick, hold_left;
    m_axis_tready = 1'b0;
    pct = 100;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 100;
          1: pct = 70;
          default: pct = 25;
        endcase
      end
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Offers one beat and waits for it to be taken. Valid drops only when a
  // gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input kind_e kind, input logic [55:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == KIND_ENCODE) n_encode++; else n_decode++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  task automatic encode_dir(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    logic [55:0] d;
    d = {8'($urandom_range(0, 255)), z, y, x};
    send_beat(KIND_ENCODE, d);
  endtask

  task automatic decode_code(input logic [7:0] c);
    logic [55:0] d;
    d = {c, 16'($urandom), 16'($urandom), 16'($urandom)};
    send_beat(KIND_DECODE, d);
  endtask

  // The extra edge lets the checker record a beat taken at the current edge.
  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Encode a random, a small, a symmetric or an extreme-x direction.
  task automatic random_encode;
    logic [15:0] x, y, z;
    int spread;
    case ($urandom_range(0, 3))
      0: begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end
      1: begin
        // Small magnitudes make many dot products tie or vanish.
        spread = $urandom_range(0, 3);
        x = 16'($urandom_range(0, 2*spread) - spread);
        y = 16'($urandom_range(0, 2*spread) - spread);
        z = 16'($urandom_range(0, 2*spread) - spread);
      end
      2: begin
        // Symmetric directions sit midway between neighboring normals.
        x = 16'($urandom);
        y = $urandom_range(0, 1) ? x : -x;
        z = $urandom_range(0, 1) ? 16'd0 : x;
      end
      default: begin
        x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        y = 16'($urandom_range(0, 4095) - 2048);
        z = $urandom_range(0, 1) ? 16'($urandom) : 16'h8000;
      end
    endcase
    encode_dir(x, y, z);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = KIND_ENCODE;
    s_axis_tdata = '0;
    n_encode = 0;
    n_decode = 0;
    burst_left = 0;
    hold_request = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero direction (no positive dot), axis extremes, a tie between
    // two normals, the last valid code and codes past the table.
    encode_dir(16'd0, 16'd0, 16'd0);
    encode_dir(16'h7fff, 16'h0000, 16'h0000);
    encode_dir(16'h8000, 16'h0000, 16'h0000);
    encode_dir(16'h0000, 16'h7fff, 16'h0000);
    encode_dir(16'h0000, 16'h8000, 16'h0000);
    encode_dir(16'h0000, 16'h0000, 16'h7fff);
    encode_dir(16'h0000, 16'h0000, 16'h8000);
    encode_dir(16'h7fff, 16'h7fff, 16'h7fff);
    encode_dir(16'h8000, 16'h8000, 16'h8000);
    encode_dir(16'h0001, 16'h0000, 16'h0000);
    encode_dir(16'hffff, 16'hffff, 16'hffff);
    encode_dir(16'h4000, 16'h4000, 16'h0000);
    decode_code(8'd0);
    decode_code(8'd5);
    decode_code(8'd52);
    decode_code(8'd143);
    decode_code(8'd161);
    decode_code(8'd162);
    decode_code(8'd255);
    decode_code(8'd128);
    wait_drained();

    // The receiver stalls for a long stretch while beats keep coming.
    hold_request = 1500;
    for (int i = 0; i < 12; i++) decode_code(8'($urandom_range(0, 255)));

    for (int i = 0; i < 1630; i++) begin
      if ($urandom_range(0, 9) < 4) random_encode();
      else if ($urandom_range(0, 4) == 0) decode_code(8'($urandom_range(162, 255)));
      else decode_code(8'($urandom_range(0, 161)));
      if (i == 800) wait_drained();
    end

    wait_drained();
    repeat (600) @(posedge clk_i);
    $display("tb: ran %0d encode and %0d decode beats under random stalls",
             n_encode, n_decode);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
